// File: hdl/rsame_pkg.sv
// Shared types, constants and codes for the RSA modular exponentiation unit.
`timescale 1ns / 1ps

package rsame_pkg;

    localparam int DATA_W    = 64;
    localparam int MOD_WIDTH = 64;
    localparam int CNT_W     = $clog2(DATA_W);
    localparam int FUNC_W    = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DATA_W - 1);

    localparam logic [FUNC_W-1:0] FUNC_PRIVATE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUBLIC  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_VERIFY  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MODULUS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PUBLIC_EXP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRIVATE_EXP = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED_BASE,
        ST_RED_MSG,
        ST_POW,
        ST_MUL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [DATA_W-1:0] message;
        logic [DATA_W-1:0] signature;
    } cmd_t;

    typedef struct packed {
        logic                 valid;
        logic [MOD_WIDTH-1:0] power;
        logic                 match;
    } res_t;

endpackage

// File: hdl/rsame_add_mod.sv
// Shared modular adder: (a + b + cin) mod n for a, b below n.
`timescale 1ns / 1ps

module rsame_add_mod (
    input  logic [rsame_pkg::MOD_WIDTH-1:0] a,
    input  logic [rsame_pkg::MOD_WIDTH-1:0] b,
    input  logic                            cin,
    input  logic [rsame_pkg::MOD_WIDTH-1:0] n,
    output logic [rsame_pkg::MOD_WIDTH-1:0] sum
);
    import rsame_pkg::*;

    logic [MOD_WIDTH:0] raw;
    logic [MOD_WIDTH:0] red;

    assign raw = {1'b0, a} + {1'b0, b} + {{MOD_WIDTH{1'b0}}, cin};
    assign red = raw - {1'b0, n};
    assign sum = (raw >= {1'b0, n}) ? red[MOD_WIDTH-1:0] : raw[MOD_WIDTH-1:0];

endmodule

// File: hdl/rsame_core.sv
// Sequencer and registers for reduction, square-and-multiply and shift-and-add.
`timescale 1ns / 1ps

module rsame_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  rsame_pkg::cmd_t                cmd,
    input  logic [rsame_pkg::DATA_W-1:0]   modulus,
    input  logic [rsame_pkg::DATA_W-1:0]   public_exponent,
    input  logic [rsame_pkg::DATA_W-1:0]   private_exponent,
    output logic                           ready,
    output rsame_pkg::res_t                res,
    input  logic                           res_take
);
    import rsame_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic [FUNC_W-1:0]    func_reg;
    logic [MOD_WIDTH-1:0] n_reg;
    logic [DATA_W-1:0]    ex_reg;
    logic [DATA_W-1:0]    src_reg;
    logic [DATA_W-1:0]    msg_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [MOD_WIDTH-1:0] acc_reg;
    logic [MOD_WIDTH-1:0] sq_reg;
    logic [MOD_WIDTH-1:0] mref_reg;
    logic [MOD_WIDTH-1:0] mx_reg;
    logic [MOD_WIDTH-1:0] my_reg;
    logic [MOD_WIDTH-1:0] mp_reg;
    logic                 mul_sq_reg;
    logic [MOD_WIDTH-1:0] power_reg;
    logic                 match_reg;

    logic [MOD_WIDTH-1:0] n_in;
    logic [MOD_WIDTH-1:0] op_a;
    logic [MOD_WIDTH-1:0] op_b;
    logic                 op_cin;
    logic [MOD_WIDTH-1:0] unit_sum;

    assign n_in = modulus[MOD_WIDTH-1:0];

    rsame_add_mod u_add_mod (
        .a   (op_a),
        .b   (op_b),
        .cin (op_cin),
        .n   (n_reg),
        .sum (unit_sum)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (n_in == '0 || cmd.func == FUNC_NONE)
                        state_next = ST_DONE;
                    else
                        state_next = ST_RED_BASE;
                end
            end
            ST_RED_BASE:
            begin
                if (cnt_reg == '0)
                    state_next = (func_reg == FUNC_VERIFY) ? ST_RED_MSG : ST_POW;
            end
            ST_RED_MSG:
            begin
                if (cnt_reg == '0)
                    state_next = ST_POW;
            end
            ST_POW:
            begin
                state_next = (ex_reg == '0) ? ST_DONE : ST_MUL;
            end
            ST_MUL:
            begin
                if (my_reg == '0 && mul_sq_reg)
                    state_next = ST_POW;
            end
            ST_DONE:
            begin
                if (res_take)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ready     = 1'b0;
        res.valid = 1'b0;
        res.power = power_reg;
        res.match = match_reg;
        op_a      = '0;
        op_b      = '0;
        op_cin    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ready = 1'b1;
            end
            ST_RED_BASE:
            begin
                op_a   = sq_reg;
                op_b   = sq_reg;
                op_cin = src_reg[DATA_W-1];
            end
            ST_RED_MSG:
            begin
                op_a   = mref_reg;
                op_b   = mref_reg;
                op_cin = src_reg[DATA_W-1];
            end
            ST_POW:
            begin
                op_a = '0;
            end
            ST_MUL:
            begin
                op_a = my_reg[0] ? mp_reg : mx_reg;
                op_b = mx_reg;
            end
            ST_DONE:
            begin
                res.valid = 1'b1;
            end
            default:
            begin
                ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    func_reg  <= cmd.func;
                    n_reg     <= n_in;
                    ex_reg    <= (cmd.func == FUNC_PRIVATE) ? private_exponent
                                                            : public_exponent;
                    src_reg   <= (cmd.func == FUNC_VERIFY) ? cmd.signature : cmd.message;
                    msg_reg   <= cmd.message;
                    cnt_reg   <= CNT_MAX;
                    sq_reg    <= '0;
                    mref_reg  <= '0;
                    acc_reg   <= (n_in == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
                    power_reg <= '0;
                    match_reg <= 1'b0;
                end
            end
            ST_RED_BASE:
            begin
                sq_reg  <= unit_sum;
                src_reg <= src_reg << 1;
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    src_reg <= msg_reg;
                    cnt_reg <= CNT_MAX;
                end
            end
            ST_RED_MSG:
            begin
                mref_reg <= unit_sum;
                src_reg  <= src_reg << 1;
                cnt_reg  <= cnt_reg - CNT_W'(1);
            end
            ST_POW:
            begin
                if (ex_reg == '0)
                begin
                    power_reg <= acc_reg;
                    match_reg <= (func_reg == FUNC_VERIFY) && (acc_reg == mref_reg);
                end
                else
                begin
                    mp_reg     <= '0;
                    mul_sq_reg <= ~ex_reg[0];
                    mx_reg     <= ex_reg[0] ? acc_reg : sq_reg;
                    my_reg     <= sq_reg;
                end
            end
            ST_MUL:
            begin
                if (my_reg == '0)
                begin
                    if (!mul_sq_reg)
                    begin
                        acc_reg    <= mp_reg;
                        mul_sq_reg <= 1'b1;
                        mx_reg     <= sq_reg;
                        my_reg     <= sq_reg;
                        mp_reg     <= '0;
                    end
                    else
                    begin
                        sq_reg <= mp_reg;
                        ex_reg <= ex_reg >> 1;
                    end
                end
                else if (my_reg[0])
                begin
                    mp_reg    <= unit_sum;
                    my_reg[0] <= 1'b0;
                end
                else
                begin
                    mx_reg <= unit_sum;
                    my_reg <= my_reg >> 1;
                end
            end
            ST_DONE:
            begin
                power_reg <= power_reg;
            end
            default:
            begin
                power_reg <= power_reg;
            end
        endcase
    end

endmodule

// File: hdl/rsa_modular_exponentiation_unit.sv
// Top level of the RSA modular exponentiation unit: key registers, stream ports, output word.
`timescale 1ns / 1ps

// Usage:
//   Write modulus, public exponent and private exponent through cfg_we/cfg_index/cfg_data
//   (index 0, 1, 2) while the unit is idle. Reset loads modulus 1, public exponent 3,
//   private exponent 1.
//   Input words arrive on s_axis: tuser selects private power, public power or verify;
//   tdata carries message and signature. One result word leaves on m_axis per input word.
//   Steps: the base is reduced first (the message too on verify), then per exponent bit up to
//   the highest set bit: a control step plus one shift-and-add product (two when the bit
//   is set), then a finish step and the load of the output register. Each product runs on
//   the single shared modular adder. A zero modulus or an unused code goes straight to the finish.
//   s_axis_tready is high only while the sequencer is idle; one word is in work at a time.
//   The result sits in an output register, so a stalled receiver holds it while the next
//   word is taken in; a finished word waits in the sequencer until that register frees.
//   Reset empties the sequencer and the output register.
module rsa_modular_exponentiation_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [rsame_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rsame_pkg::DATA_W-1:0]         cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [2*rsame_pkg::DATA_W-1:0]       s_axis_tdata,   // message, signature
    input  logic [rsame_pkg::FUNC_W-1:0]         s_axis_tuser,   // func
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [rsame_pkg::DATA_W-1:0]         m_axis_tdata,   // power_result
    output logic                                 m_axis_tuser    // match_res
);
    import rsame_pkg::*;

    logic [DATA_W-1:0] modulus_reg;
    logic [DATA_W-1:0] pub_exp_reg;
    logic [DATA_W-1:0] priv_exp_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_power_reg;
    logic              out_match_reg;

    cmd_t cmd;
    res_t res;
    logic core_ready;
    logic start;
    logic res_take;

    assign cmd.func      = s_axis_tuser;
    assign cmd.message   = s_axis_tdata[DATA_W-1:0];
    assign cmd.signature = s_axis_tdata[2*DATA_W-1:DATA_W];

    assign s_axis_tready = core_ready;
    assign start         = s_axis_tvalid & core_ready;
    assign res_take      = res.valid & (~out_valid_reg | m_axis_tready);

    rsame_core u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .cmd              (cmd),
        .modulus          (modulus_reg),
        .public_exponent  (pub_exp_reg),
        .private_exponent (priv_exp_reg),
        .ready            (core_ready),
        .res              (res),
        .res_take         (res_take)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= DATA_W'(1);
            pub_exp_reg  <= DATA_W'(3);
            priv_exp_reg <= DATA_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODULUS:     modulus_reg  <= cfg_data;
                REG_PUBLIC_EXP:  pub_exp_reg  <= cfg_data;
                REG_PRIVATE_EXP: priv_exp_reg <= cfg_data;
                default:         modulus_reg  <= modulus_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_power_reg <= DATA_W'(res.power);
            out_match_reg <= res.match;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_power_reg;
    assign m_axis_tuser  = out_match_reg;

endmodule

// File: hdl/rsame_checker.sv
// Port-level checks for the RSA modular exponentiation unit, bound to the top level.
`timescale 1ns / 1ps

module rsame_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    input  logic                                 s_axis_tready,
    input  logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic [rsame_pkg::DATA_W-1:0]         m_axis_tdata,
    input  logic                                 m_axis_tuser
);
    import rsame_pkg::*;

    logic in_acc;

    assign in_acc = s_axis_tvalid & s_axis_tready;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !s_axis_tready)
        else $error("input ready while a word is in work");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !$rose(m_axis_tvalid))
        else $error("result word appeared one cycle after accept");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result word changed");

endmodule

bind rsa_modular_exponentiation_unit rsame_checker u_rsame_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
